### sv/crse_pkg.sv
// Shared types and constants for the Catmull-Rom spline evaluator.
// Used by crse_horner and catmull_rom_spline_eval; depends on nothing else.
package crse_pkg;

    // Store geometry.
    localparam int MAX_POINTS = 64;
    localparam int MIN_POINTS = 4;
    localparam int ADDR_W     = $clog2(MAX_POINTS);

    // Field widths.
    localparam int COORD_W = 32;
    localparam int POINT_W = 3 * COORD_W;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int POS_W   = 17;

    // Width of the position scaled by the segment count.
    localparam int SCALED_W = POS_W + COUNT_W;

    // Q1.16 value of one.
    localparam logic [POS_W-1:0] Q_ONE = POS_W'(65536);

    // Datapath widths for the Horner evaluation.
    localparam int H_W    = 40;
    localparam int PROD_W = H_W + POS_W + 1;

    // Edges from acceptance of an evaluate transaction to the result register.
    localparam int PIPE_DEPTH = 9;

    // Transaction opcodes.
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [H_W-1:0]     hval_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

endpackage

### sv/crse_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Self-contained; no package dependency.
module crse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### sv/crse_horner.sv
// One axis of the Catmull-Rom cubic: basis sums, three Horner steps, saturation.
// Depends on crse_pkg. Pure datapath; the caller tracks which stages hold valid data.
module crse_horner (
    input  logic                          clk,
    input  crse_pkg::coord_t              p0,
    input  crse_pkg::coord_t              p1,
    input  crse_pkg::coord_t              p2,
    input  crse_pkg::coord_t              p3,
    input  logic [crse_pkg::POS_W-1:0]    u,
    output crse_pkg::coord_t              result
);
    import crse_pkg::*;

    hval_t              e3_reg, e2_reg, e1_reg, e0_reg;
    hval_t              e3_next, e2_next, e1_next, e0_next;
    hval_t              x0, x1, x2, x3;
    logic [POS_W-1:0]   u_s1_reg, u_s2_reg, u_s3_reg, u_s4_reg, u_s5_reg;
    hval_t              e2_s2_reg;
    hval_t              e1_s2_reg, e1_s3_reg, e1_s4_reg;
    hval_t              e0_s2_reg, e0_s3_reg, e0_s4_reg, e0_s5_reg, e0_s6_reg;
    prod_t              prod1_reg, prod2_reg, prod3_reg;
    hval_t              h1_reg, h2_reg, h3_reg;
    hval_t              h1_next, h2_next, h3_next;
    hval_t              half;
    coord_t             result_reg, result_next;

    // Round a Q16 product to nearest, ties upward, and drop the fraction.
    function automatic hval_t rnd16(input prod_t v);
        prod_t s;
        s = (v + PROD_W'(32768)) >>> 16;
        return s[H_W-1:0];
    endfunction

    // Multiply by the non-negative local parameter.
    function automatic prod_t mul_u(input hval_t h, input logic [POS_W-1:0] uu);
        prod_t a;
        prod_t b;
        a = PROD_W'(h);
        b = $signed({{(PROD_W-POS_W){1'b0}}, uu});
        return a * b;
    endfunction

    // Basis coefficient sums from the four control points.
    always_comb
    begin
        x0 = H_W'(p0);
        x1 = H_W'(p1);
        x2 = H_W'(p2);
        x3 = H_W'(p3);
        e3_next = -x0 + (x1 <<< 1) + x1 - (x2 <<< 1) - x2 + x3;
        e2_next = (x0 <<< 1) - (x1 <<< 2) - x1 + (x2 <<< 2) - x3;
        e1_next = x2 - x0;
        e0_next = x1 <<< 1;
    end

    // Additions after each product.
    always_comb
    begin
        h1_next = rnd16(prod1_reg) + e2_s2_reg;
        h2_next = rnd16(prod2_reg) + e1_s4_reg;
        h3_next = rnd16(prod3_reg) + e0_s6_reg;
    end

    // Final halving with rounding and saturation to Q16.16.
    always_comb
    begin
        half = (h3_reg + H_W'(1)) >>> 1;
        if (half > H_W'(32'sh7fff_ffff))
        begin
            result_next = 32'sh7fff_ffff;
        end
        else if (half < -H_W'(64'sh8000_0000))
        begin
            result_next = 32'sh8000_0000;
        end
        else
        begin
            result_next = half[COORD_W-1:0];
        end
    end

    // Pipeline registers: sums, then product and sum alternately for each step, then the result.
    always_ff @(posedge clk)
    begin
        e3_reg     <= e3_next;
        e2_reg     <= e2_next;
        e1_reg     <= e1_next;
        e0_reg     <= e0_next;
        u_s1_reg   <= u;

        prod1_reg  <= mul_u(e3_reg, u_s1_reg);
        e2_s2_reg  <= e2_reg;
        e1_s2_reg  <= e1_reg;
        e0_s2_reg  <= e0_reg;
        u_s2_reg   <= u_s1_reg;

        h1_reg     <= h1_next;
        e1_s3_reg  <= e1_s2_reg;
        e0_s3_reg  <= e0_s2_reg;
        u_s3_reg   <= u_s2_reg;

        prod2_reg  <= mul_u(h1_reg, u_s3_reg);
        e1_s4_reg  <= e1_s3_reg;
        e0_s4_reg  <= e0_s3_reg;
        u_s4_reg   <= u_s3_reg;

        h2_reg     <= h2_next;
        e0_s5_reg  <= e0_s4_reg;
        u_s5_reg   <= u_s4_reg;

        prod3_reg  <= mul_u(h2_reg, u_s5_reg);
        e0_s6_reg  <= e0_s5_reg;

        h3_reg     <= h3_next;

        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

### sv/catmull_rom_spline_eval.sv
// Top level of the uniform Catmull-Rom spline evaluator.
// Depends on crse_pkg, crse_ram (point store) and crse_horner (per-axis cubic).

// The block takes one transaction in every clock cycle and busy is always low.
// A write transaction stores one control point and gives no result. An evaluate
// transaction gives its result on out_x/out_y/out_z with done high for one cycle,
// after the registered store read, the basis sums, the three product and sum steps
// and the result register; results leave in the order the evaluations came in, and
// the receiver cannot stall them. The point store is two mirrored dual-read RAMs,
// so all four neighbouring points are read in the same cycle, and the multiplier
// of each Horner step is pipelined. A point written in a cycle is visible to an
// evaluate in the next. The store has no reset and no clearing pass: only entries
// that have been written may be used. The user must write point_count through
// cfg_we/cfg_wdata while no evaluation is in flight; the block does not check it.
module catmull_rom_spline_eval (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  crse_pkg::op_t                     op,
    input  logic [crse_pkg::INDEX_W-1:0]      point_index,
    input  crse_pkg::coord_t                  in_x,
    input  crse_pkg::coord_t                  in_y,
    input  crse_pkg::coord_t                  in_z,
    input  logic [crse_pkg::POS_W-1:0]        eval_pos,
    input  logic                              cfg_we,
    input  logic [crse_pkg::COUNT_W-1:0]      cfg_wdata,
    output logic                              done,
    output crse_pkg::coord_t                  out_x,
    output crse_pkg::coord_t                  out_y,
    output crse_pkg::coord_t                  out_z
);
    import crse_pkg::*;

    logic [COUNT_W-1:0]    point_count_reg;
    logic [COUNT_W-1:0]    n_eff;
    logic [COUNT_W-1:0]    n_m1, n_m2;
    logic [POS_W-1:0]      t_clamped;
    logic [SCALED_W-1:0]   scaled;
    logic [COUNT_W-1:0]    seg_raw, seg;
    logic [COUNT_W-1:0]    idx0, idx1, idx2, idx3;
    logic [POS_W-1:0]      u_next, u_reg;
    logic                  eval_fire, write_fire;
    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;
    logic [POINT_W-1:0]    wr_point;
    logic [POINT_W-1:0]    pt0, pt1, pt2, pt3;
    coord_t                res [3];

    assign busy       = 1'b0;
    assign eval_fire  = start && !busy && (op == OP_EVAL);
    assign write_fire = start && !busy && (op == OP_WRITE)
                        && (32'(point_index) < MAX_POINTS);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= COUNT_W'(MIN_POINTS);
        end
        else if (cfg_we)
        begin
            point_count_reg <= cfg_wdata;
        end
    end

    // Effective count, segment, local parameter and neighbour addresses.
    always_comb
    begin
        if (point_count_reg < COUNT_W'(MIN_POINTS))
        begin
            n_eff = COUNT_W'(MIN_POINTS);
        end
        else if (32'(point_count_reg) > MAX_POINTS)
        begin
            n_eff = COUNT_W'(MAX_POINTS);
        end
        else
        begin
            n_eff = point_count_reg;
        end
        n_m1 = n_eff - COUNT_W'(1);
        n_m2 = n_eff - COUNT_W'(2);

        t_clamped = (eval_pos > Q_ONE) ? Q_ONE : eval_pos;
        scaled    = SCALED_W'(t_clamped) * SCALED_W'(n_m1);
        seg_raw   = scaled[SCALED_W-2:16];

        if (seg_raw > n_m2)
        begin
            seg    = n_m2;
            u_next = Q_ONE;
        end
        else
        begin
            seg    = seg_raw;
            u_next = {1'b0, scaled[15:0]};
        end

        // Outer neighbours fall back to the nearest inner point at the ends.
        idx1 = seg;
        idx2 = seg + COUNT_W'(1);
        idx0 = (seg == '0) ? seg : seg - COUNT_W'(1);
        idx3 = (seg + COUNT_W'(2) >= n_eff) ? seg + COUNT_W'(1) : seg + COUNT_W'(2);
    end

    assign wr_point = {in_z, in_y, in_x};

    // Point store: two mirrored copies give four reads per cycle.
    crse_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_store_lo (
        .clk     (clk),
        .we      (write_fire),
        .waddr   (ADDR_W'(point_index)),
        .wdata   (wr_point),
        .raddr_a (ADDR_W'(idx0)),
        .raddr_b (ADDR_W'(idx1)),
        .rdata_a (pt0),
        .rdata_b (pt1)
    );

    crse_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_store_hi (
        .clk     (clk),
        .we      (write_fire),
        .waddr   (ADDR_W'(point_index)),
        .wdata   (wr_point),
        .raddr_a (ADDR_W'(idx2)),
        .raddr_b (ADDR_W'(idx3)),
        .rdata_a (pt2),
        .rdata_b (pt3)
    );

    // Local parameter travels alongside the read data.
    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
    end

    // One cubic evaluator per axis.
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        crse_horner u_horner (
            .clk    (clk),
            .p0     (pt0[a*COORD_W +: COORD_W]),
            .p1     (pt1[a*COORD_W +: COORD_W]),
            .p2     (pt2[a*COORD_W +: COORD_W]),
            .p3     (pt3[a*COORD_W +: COORD_W]),
            .u      (u_reg),
            .result (res[a])
        );
    end

    // Valid marks follow each evaluate transaction down the pipeline.
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], eval_fire};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign done  = vld_reg[PIPE_DEPTH-1];
    assign out_x = res[0];
    assign out_y = res[1];
    assign out_z = res[2];

`ifndef SYNTHESIS
    // Every result strobe comes from a matching earlier evaluate transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(eval_fire, PIPE_DEPTH))
        else $error("result strobe without a matching evaluate transaction");

    // Every evaluate yields a result; none is lost in the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        eval_fire |-> ##(PIPE_DEPTH) done)
        else $error("evaluate transaction lost in the pipeline");

    // Neighbour addresses stay inside the points in use and are ordered.
    assert property (@(posedge clk) disable iff (!rst_n)
        eval_fire |-> (idx3 < n_eff) && (idx0 <= idx1) && (idx2 == idx1 + COUNT_W'(1))
                      && (idx3 >= idx2))
        else $error("neighbour address out of range");

    // The local parameter never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        eval_fire |=> (u_reg <= Q_ONE))
        else $error("local parameter above one");
`endif

endmodule
